### rtl/clcd_pkg.sv
// shared types, constants and register codes for the color line classifier
`timescale 1ns / 1ps
package clcd_pkg;

   localparam int ColorWidth  = 16;
   localparam int SqWidth     = 2 * ColorWidth;
   localparam int SumWidth    = SqWidth + 2;
   localparam int DistWidth   = SumWidth / 2;
   localparam int NumDist     = 6;
   localparam int DriveWidth  = 9;
   localparam int CsrWidth    = 48;
   localparam int CsrIdxWidth = 3;
   localparam int SqrtStages  = 3;

   localparam logic [ColorWidth-1:0] WhiteQ15 = 16'd32768;

   // register indexes
   typedef enum logic [CsrIdxWidth-1:0] {
      REG_BLACK  = 3'd0,
      REG_RED    = 3'd1,
      REG_GREEN  = 3'd2,
      REG_BLUE   = 3'd3,
      REG_BOARD  = 3'd4,
      REG_SPEEDS = 3'd5,
      REG_LIMITS = 3'd6,
      REG_MASK   = 3'd7
   } csr_idx_type;

   localparam logic [15:0] SpeedsReset = 16'd28300;
   localparam logic [31:0] LimitsReset = 32'd107353866;
   localparam logic [3:0]  MaskReset   = 4'd3;

   // per-item side data that travels beside the distances
   typedef struct packed {
      logic ir_left;
      logic ir_right;
      logic obstacle;
   } side_type;

   // partial square-root state: remainder and root so far
   typedef struct packed {
      logic [SumWidth-1:0]  rem;
      logic [DistWidth-1:0] root;
   } sqrt_type;

endpackage

### rtl/clcd_sqrt_stage.sv
// one registered slice of a restoring integer square root, NumBits result bits per stage
`timescale 1ns / 1ps
module clcd_sqrt_stage
   import clcd_pkg::*;
#(
   parameter int FirstBit = 0,
   parameter int NumBits  = 1
) (
   input  logic     clock,
   input  sqrt_type in_state,
   output sqrt_type out_state
);

   sqrt_type state_in;
   sqrt_type state_ff;

   // one result bit per step, most significant first
   always_comb begin
      logic [SumWidth-1:0] trial;
      state_in = in_state;
      for (int k = 0; k < NumBits; k++) begin
         trial = ({{(SumWidth-DistWidth){1'b0}}, state_in.root} << (FirstBit - k + 1))
               | ({{(SumWidth-1){1'b0}}, 1'b1} << (2 * (FirstBit - k)));
         if (state_in.rem >= trial) begin
            state_in.rem                  = state_in.rem - trial;
            state_in.root[FirstBit - k]   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      state_ff <= state_in;
   end

   assign out_state = state_ff;

endmodule

### rtl/clcd_distance.sv
// squared distance then pipelined integer square root for one target color
`timescale 1ns / 1ps
module clcd_distance
   import clcd_pkg::*;
(
   input  logic                  clock,
   input  logic [ColorWidth-1:0] red,
   input  logic [ColorWidth-1:0] green,
   input  logic [ColorWidth-1:0] blue,
   input  logic [3*ColorWidth-1:0] target,
   output logic [DistWidth-1:0]  dist_out
);

   logic [ColorWidth-1:0] dr_ff, dg_ff, db_ff;
   logic [SqWidth-1:0]    sr_ff, sg_ff, sb_ff;
   logic [SumWidth-1:0]   sum_ff;
   sqrt_type              s0, s1, s2, s3;

   function automatic logic [ColorWidth-1:0] absdiff(input logic [ColorWidth-1:0] a,
                                                     input logic [ColorWidth-1:0] b);
      absdiff = (a >= b) ? a - b : b - a;
   endfunction

   // stage 1: differences, stage 2: squares, stage 3: sum
   always_ff @(posedge clock) begin
      dr_ff  <= absdiff(red,   target[47:32]);
      dg_ff  <= absdiff(green, target[31:16]);
      db_ff  <= absdiff(blue,  target[15:0]);
      sr_ff  <= dr_ff * dr_ff;
      sg_ff  <= dg_ff * dg_ff;
      sb_ff  <= db_ff * db_ff;
      sum_ff <= SumWidth'(sr_ff) + SumWidth'(sg_ff) + SumWidth'(sb_ff);
   end

   assign s0.rem  = sum_ff;
   assign s0.root = '0;

   // three root stages of six, six and five bits
   clcd_sqrt_stage #(.FirstBit(16), .NumBits(6)) u_sq0 (.clock, .in_state(s0), .out_state(s1));
   clcd_sqrt_stage #(.FirstBit(10), .NumBits(6)) u_sq1 (.clock, .in_state(s1), .out_state(s2));
   clcd_sqrt_stage #(.FirstBit(4),  .NumBits(5)) u_sq2 (.clock, .in_state(s2), .out_state(s3));

   assign dist_out = s3.root;

endmodule

### rtl/color_line_classifier_drive_top.sv
// top level: config registers, six distance pipelines, decision and drive stages
`timescale 1ns / 1ps
// One sample is taken in every clock cycle while start is high; busy is always low.
// The result shows on the rsp_ ports with rsp_valid high for one cycle.
// Registers in order form the squared distances, run the square root, pick the
// nearest line color and make the drive command. Results cannot be held off.
// Configuration is sampled along the pipeline, so write it only while no sample
// is in flight.
module color_line_classifier_drive_top
   import clcd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [ColorWidth-1:0]  req_color_red,
   input  logic [ColorWidth-1:0]  req_color_green,
   input  logic [ColorWidth-1:0]  req_color_blue,
   input  logic                   req_ir_left,
   input  logic                   req_ir_right,
   input  logic                   req_obstacle,
   input  logic                   csr_write,
   input  logic [CsrIdxWidth-1:0] csr_index,
   input  logic [CsrWidth-1:0]    csr_data,
   output logic                   rsp_valid,
   output logic signed [DriveWidth-1:0] rsp_left_drive,
   output logic signed [DriveWidth-1:0] rsp_right_drive,
   output logic                   rsp_motor_update,
   output logic                   rsp_on_line,
   output logic                   rsp_avoid_request
);

   localparam int DistLat = 6;
   localparam int Lat     = DistLat + 2;

   logic [CsrWidth-1:0] tgt_ff [5];
   logic [15:0]         speeds_ff;
   logic [31:0]         limits_ff;
   logic [3:0]          mask_ff;

   logic [DistWidth-1:0] lane_dist [NumDist];
   logic [Lat-1:0]       valid_ff;
   side_type             side_ff [DistLat];

   logic [DistWidth-1:0] best_ff, bg_ff;
   logic                 any_ff;
   side_type             side7_ff;

   logic [DistWidth-1:0] best_in;
   logic                 any_in;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 5; i++) tgt_ff[i] <= '0;
         speeds_ff <= SpeedsReset;
         limits_ff <= LimitsReset;
         mask_ff   <= MaskReset;
      end else if (csr_write) begin
         unique case (csr_idx_type'(csr_index))
            REG_BLACK:  tgt_ff[0] <= csr_data;
            REG_RED:    tgt_ff[1] <= csr_data;
            REG_GREEN:  tgt_ff[2] <= csr_data;
            REG_BLUE:   tgt_ff[3] <= csr_data;
            REG_BOARD:  tgt_ff[4] <= csr_data;
            REG_SPEEDS: speeds_ff <= csr_data[15:0];
            REG_LIMITS: limits_ff <= csr_data[31:0];
            REG_MASK:   mask_ff   <= csr_data[3:0];
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   // distance lanes: four line targets, board, white
   for (genvar i = 0; i < NumDist; i++) begin : g_lane
      logic [3*ColorWidth-1:0] tgt;
      if (i < 5) begin : g_cfg
         assign tgt = tgt_ff[i];
      end else begin : g_white
         assign tgt = {WhiteQ15, WhiteQ15, WhiteQ15};
      end
      clcd_distance u_dist (
         .clock, .red(req_color_red), .green(req_color_green), .blue(req_color_blue),
         .target(tgt), .dist_out(lane_dist[i])
      );
   end

   // valid bits and side data beside the distance pipes
   always_ff @(posedge clock) begin
      if (reset) valid_ff <= '0;
      else       valid_ff <= {valid_ff[Lat-2:0], start};
   end

   always_ff @(posedge clock) begin
      side_ff[0] <= '{req_ir_left, req_ir_right, req_obstacle};
      for (int i = 1; i < DistLat; i++) side_ff[i] <= side_ff[i-1];
   end

   // nearest allowed line color and nearer background
   always_comb begin
      logic [DistWidth-1:0] b;
      logic                 a;
      b = '0;
      a = 1'b0;
      for (int i = 0; i < 4; i++) begin
         if (mask_ff[i] && (!a || lane_dist[i] < b)) b = lane_dist[i];
         if (mask_ff[i]) a = 1'b1;
      end
      best_in = b;
      any_in  = a;
   end

   always_ff @(posedge clock) begin
      best_ff  <= best_in;
      any_ff   <= any_in;
      bg_ff    <= (lane_dist[4] < lane_dist[5]) ? lane_dist[4] : lane_dist[5];
      side7_ff <= side_ff[DistLat-1];
   end

   // threshold test and drive command
   logic on_in;
   logic [DriveWidth-1:0] pos_turn, neg_turn, base;
   assign on_in = any_ff && (best_ff <= DistWidth'(limits_ff[15:0]))
                 && ((DistWidth'(best_ff) + DistWidth'(limits_ff[31:16])) < bg_ff);
   assign pos_turn = {1'b0, speeds_ff[15:8]};
   assign neg_turn = DriveWidth'(0) - pos_turn;
   assign base     = {1'b0, speeds_ff[7:0]};

   always_ff @(posedge clock) begin
      if (side7_ff.obstacle) begin
         rsp_left_drive    <= '0;
         rsp_right_drive   <= '0;
         rsp_motor_update  <= 1'b0;
         rsp_on_line       <= 1'b0;
         rsp_avoid_request <= 1'b1;
      end else begin
         rsp_motor_update  <= 1'b1;
         rsp_on_line       <= on_in;
         rsp_avoid_request <= 1'b0;
         if (on_in) begin
            rsp_left_drive  <= base;
            rsp_right_drive <= base;
         end else if (side7_ff.ir_left && !side7_ff.ir_right) begin
            rsp_left_drive  <= neg_turn;
            rsp_right_drive <= pos_turn;
         end else begin
            rsp_left_drive  <= pos_turn;
            rsp_right_drive <= neg_turn;
         end
      end
   end

   assign rsp_valid = valid_ff[Lat-1];

   // checks
   a_latency: assert property (@(posedge clock) disable iff (reset)
      start |-> ##8 rsp_valid) else $error("result latency broken");
   a_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_motor_update != rsp_avoid_request)) else $error("command and avoid");
   a_online: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_on_line) |-> rsp_motor_update) else $error("on line without command");

endmodule
